[hdl/lsms_pkg.sv]
package lsms_pkg;

    localparam int NUM_SLOTS = 4096;
    localparam int SLOT_W    = 12;
    localparam int LIM_W     = 17;
    localparam int DB_W      = 16;
    // extrapolated change: three floored products of 48 bits summed
    localparam int DL_W      = 50;
    localparam int QUOT_W    = 16;

    localparam logic [LIM_W-1:0] LIM_ONE  = 17'd65536;
    localparam logic [LIM_W-1:0] LIM_ZERO = 17'd0;

    localparam logic REQ_UPDATE = 1'b0;
    localparam logic REQ_SET    = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic [SLOT_W-1:0]  slot;
        logic               active;
        logic signed [31:0] value;
        logic signed [31:0] grad_x;
        logic signed [31:0] grad_y;
        logic signed [31:0] grad_z;
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic signed [31:0] offset_z;
        logic signed [31:0] value_max;
        logic signed [31:0] value_min;
    } t_in_word;

    typedef struct packed {
        logic [SLOT_W-1:0] slot_out;
        logic [LIM_W-1:0]  limiter_new;
        logic [LIM_W-1:0]  candidate;
    } t_out_word;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [SLOT_W-1:0] addr;
        logic [LIM_W-1:0]  wr_data;
    } t_store_req;

endpackage

[hdl/slope_limiter_min_store.sv]
// channel   direction  valid     stall     word
// input     in         i_valid   o_stall   i_word
// output    out        o_valid   i_stall   o_word
// config    in         i_cfg_wr_en  -      i_cfg_wr_data
//
// one item at a time; a set request or inactive facet skips to the write-back,
// an update passes multiply, sum, check and, when run, the 16-step serial divider
// the shared 32x32 multiplier forms the three products one after another
// after reset the limiter memory is swept to one, o_stall high
// a result waiting in the output register holds back only the write-back
module slope_limiter_min_store (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [lsms_pkg::DB_W-1:0]     i_cfg_wr_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  lsms_pkg::t_in_word            i_word,
    output logic                          o_valid,
    input  logic                          i_stall,
    output lsms_pkg::t_out_word           o_word
);
    import lsms_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL  = 6'b000010,
        ST_SUM  = 6'b000100,
        ST_CHK  = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_UPD  = 6'b100000
    } t_state;

    t_state             r_state;
    logic [DB_W-1:0]    r_dead_band;
    t_in_word           r_item;
    logic [1:0]         r_cnt;
    logic signed [63:0] r_prod;
    logic signed [DL_W-1:0] r_acc;
    logic [LIM_W-1:0]   r_cand;
    logic               r_o_valid;
    t_out_word          r_o_word;

    t_store_req         w_req;
    logic [LIM_W-1:0]   w_rd_data;
    logic               w_store_ready;
    logic               w_accept;
    logic               w_out_free;
    logic signed [31:0] w_mul_a;
    logic signed [31:0] w_mul_b;
    logic signed [DL_W-1:0] w_prod_fl;
    logic [DL_W-1:0]    w_mag;
    logic               w_zero;
    logic signed [32:0] w_num;
    logic [DL_W-1:0]    w_num_ext;
    logic               w_div_start;
    logic               w_div_done;
    logic [QUOT_W-1:0]  w_quot;
    logic               w_in_range;
    logic [LIM_W-1:0]   w_new;

    // handshake
    assign o_stall    = !((r_state == ST_IDLE) && w_store_ready);
    assign w_accept   = i_valid && !o_stall;
    assign w_out_free = !r_o_valid || !i_stall;

    // dead band register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_band <= 16'd1;
        end else if (i_cfg_wr_en) begin
            r_dead_band <= i_cfg_wr_data;
        end
    end

    // shared multiplier operands
    always_comb begin
        case (r_cnt)
            2'd0: begin
                w_mul_a = r_item.grad_x;
                w_mul_b = r_item.offset_x;
            end
            2'd1: begin
                w_mul_a = r_item.grad_y;
                w_mul_b = r_item.offset_y;
            end
            default: begin
                w_mul_a = r_item.grad_z;
                w_mul_b = r_item.offset_z;
            end
        endcase
    end

    // floor to Q34.16 (16 fraction bits) is an arithmetic shift
    assign w_prod_fl = {{2{r_prod[63]}}, r_prod[63:16]};

    // limiter candidate decision
    assign w_mag     = r_acc[DL_W-1] ? DL_W'(-r_acc) : DL_W'(r_acc);
    assign w_zero    = (r_acc == '0) || (w_mag < DL_W'(r_dead_band));
    assign w_num     = r_acc[DL_W-1]
                     ? (33'(r_item.value) - 33'(r_item.value_min))
                     : (33'(r_item.value_max) - 33'(r_item.value));
    assign w_num_ext = DL_W'(w_num[31:0]);
    assign w_div_start = (r_state == ST_CHK) && !w_zero && !w_num[32]
                       && (w_num != '0) && (w_num_ext < w_mag);

    lsms_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num[31:0]),
        .i_den   (w_mag),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // read-modify-write of the stored limiter
    assign w_in_range = {1'b0, r_item.slot} < (SLOT_W+1)'(NUM_SLOTS);
    always_comb begin
        if (r_item.req_type == REQ_SET) begin
            w_new = LIM_ONE;
        end else if (r_item.active && (w_rd_data > r_cand)) begin
            w_new = r_cand;
        end else begin
            w_new = w_rd_data;
        end
    end

    always_comb begin
        w_req.rd_en   = w_accept;
        w_req.wr_en   = (r_state == ST_UPD) && w_out_free && w_in_range;
        w_req.addr    = w_accept ? i_word.slot : r_item.slot;
        w_req.wr_data = w_new;
    end

    lsms_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_req),
        .o_rd_data (w_rd_data),
        .o_ready   (w_store_ready)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_cnt <= '0;
                        if (i_word.req_type == REQ_SET || !i_word.active) begin
                            r_state <= ST_UPD;
                        end else begin
                            r_state <= ST_MUL;
                        end
                    end
                end
                ST_MUL: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 2'd2) begin
                        r_state <= ST_SUM;
                    end
                end
                ST_SUM: r_state <= ST_CHK;
                ST_CHK: r_state <= w_div_start ? ST_DIV : ST_UPD;
                ST_DIV: begin
                    if (w_div_done) begin
                        r_state <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // item datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_word;
            r_acc  <= '0;
            if (i_word.req_type == REQ_SET) begin
                r_cand <= LIM_ONE;
            end else begin
                r_cand <= LIM_ZERO;
            end
        end
        if (r_state == ST_MUL) begin
            r_prod <= w_mul_a * w_mul_b;
            if (r_cnt != 2'd0) begin
                r_acc <= r_acc + w_prod_fl;
            end
        end
        if (r_state == ST_SUM) begin
            r_acc <= r_acc + w_prod_fl;
        end
        if (r_state == ST_CHK) begin
            if (w_zero || w_num[32] || (w_num == '0)) begin
                r_cand <= LIM_ZERO;
            end else if (!w_div_start) begin
                r_cand <= LIM_ONE;
            end
        end
        if ((r_state == ST_DIV) && w_div_done) begin
            r_cand <= {1'b0, w_quot};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if ((r_state == ST_UPD) && w_out_free) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_UPD) && w_out_free) begin
            r_o_word.slot_out    <= r_item.slot;
            r_o_word.limiter_new <= w_in_range ? w_new : LIM_ZERO;
            r_o_word.candidate   <= r_cand;
        end
    end

    assign o_valid = r_o_valid;
    assign o_word  = r_o_word;

endmodule

[hdl/lsms_store.sv]
module lsms_store (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lsms_pkg::t_store_req         i_req,
    output logic [lsms_pkg::LIM_W-1:0]   o_rd_data,
    output logic                         o_ready
);
    import lsms_pkg::*;

    logic [LIM_W-1:0]  r_mem [NUM_SLOTS];
    logic [LIM_W-1:0]  r_rd_data;
    logic              r_clearing;
    logic [SLOT_W-1:0] r_clr_addr;

    // clearing sweep after reset, one entry a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == SLOT_W'(NUM_SLOTS - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // write port
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= LIM_ONE;
        end else if (i_req.wr_en) begin
            r_mem[i_req.addr] <= i_req.wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_ready   = !r_clearing;

endmodule

[hdl/lsms_div.sv]
module lsms_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [31:0]                   i_num,
    input  logic [lsms_pkg::DL_W-1:0]     i_den,
    output logic                          o_done,
    output logic [lsms_pkg::QUOT_W-1:0]   o_quot
);
    import lsms_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [3:0]        r_cnt;
    logic [DL_W:0]     r_rem;
    logic [DL_W-1:0]   r_den;
    logic [QUOT_W-1:0] r_quot;
    logic [DL_W:0]     w_sh;
    logic              w_ge;

    // one restoring step: remainder stays below the divisor
    assign w_sh = {r_rem[DL_W-1:0], 1'b0};
    assign w_ge = w_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 4'(QUOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= (DL_W+1)'(i_num);
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= w_ge ? (w_sh - {1'b0, r_den}) : w_sh;
            r_quot <= {r_quot[QUOT_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule
